[sv/dtv_pkg.sv]
// Shared types, status codes and small calendar tables for the date/time
// validator and packed BCD encoder. No dependencies.
package dtv_pkg;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_BAD_TIME = 2'd2
   } dtv_status_type;

   localparam logic [7:0] YEAR_MAX   = 8'd99;
   localparam logic [7:0] MONTH_MAX  = 8'd12;
   localparam logic [7:0] HOUR_LIMIT = 8'd24;
   localparam logic [7:0] MS_LIMIT   = 8'd60;
   localparam logic [4:0] LEAP_FEB   = 5'd29;
   // 2483 + offsets, reduced mod 7 (century terms cancel over 1999..2099)
   localparam logic [7:0] WEEK_BASE  = 8'd5;

   typedef struct packed {
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } dtv_time_type;

   typedef struct packed {
      dtv_status_type status;
      logic [2:0]     weekday;
   } dtv_check_type;

   typedef struct packed {
      dtv_status_type status;
      logic [6:0]     second_bcd;
      logic [6:0]     minute_bcd;
      logic [5:0]     hour_bcd;
      logic [2:0]     weekday_bcd;
      logic [5:0]     day_bcd;
      logic [4:0]     month_bcd;
      logic [7:0]     year_bcd;
   } dtv_result_type;

   function automatic logic [4:0] month_len(input logic [3:0] mo);
      case (mo)
         4'd2:    month_len = 5'd28;
         4'd4:    month_len = 5'd30;
         4'd6:    month_len = 5'd30;
         4'd9:    month_len = 5'd30;
         4'd11:   month_len = 5'd30;
         default: month_len = 5'd31;
      endcase
   endfunction

   function automatic logic [2:0] month_shift(input logic [3:0] mo);
      case (mo)
         4'd1:    month_shift = 3'd0;
         4'd2:    month_shift = 3'd3;
         4'd3:    month_shift = 3'd2;
         4'd4:    month_shift = 3'd5;
         4'd5:    month_shift = 3'd0;
         4'd6:    month_shift = 3'd3;
         4'd7:    month_shift = 3'd5;
         4'd8:    month_shift = 3'd1;
         4'd9:    month_shift = 3'd4;
         4'd10:   month_shift = 3'd6;
         4'd11:   month_shift = 3'd2;
         4'd12:   month_shift = 3'd4;
         default: month_shift = 3'd0;
      endcase
   endfunction

   // 8 = 1 mod 7: fold octal digits, then one conditional subtract
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [4:0] s;
      logic [3:0] x;
      s = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[7:6]);
      x = 4'(s[2:0]) + 4'(s[4:3]);
      mod7 = (x >= 4'd7) ? 3'(x - 4'd7) : x[2:0];
   endfunction

   // Two-digit packed BCD; tens by reciprocal multiply, exact for 0..99
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(7'(tens) * 7'd10);
      to_bcd = {tens, ones[3:0]};
   endfunction

endpackage

[sv/dtv_check.sv]
// Date and time range checks plus day-of-week computation.
// Depends on dtv_pkg.
module dtv_check (
   input  dtv_pkg::dtv_time_type  tm,
   output dtv_pkg::dtv_check_type chk
);

   logic       leap;
   logic [4:0] mlen;
   logic       date_ok;
   logic       time_ok;
   logic       jan_feb;
   logic [6:0] yr_adj;
   logic [7:0] yr_quarter;
   logic [7:0] week_sum;

   // 2000 is a multiple of 400, so the leap rule reduces to year mod 4
   assign leap = (tm.year[1:0] == 2'd0);
   assign mlen = (tm.month == 8'd2 && leap) ? dtv_pkg::LEAP_FEB
                                              : dtv_pkg::month_len(tm.month[3:0]);

   assign date_ok = (tm.year <= dtv_pkg::YEAR_MAX) && (tm.month != 8'd0)
                 && (tm.month <= dtv_pkg::MONTH_MAX) && (tm.day != 8'd0)
                 && (tm.day <= 8'(mlen));
   assign time_ok = (tm.hour < dtv_pkg::HOUR_LIMIT) && (tm.minute < dtv_pkg::MS_LIMIT)
                 && (tm.second < dtv_pkg::MS_LIMIT);

   // Year counted from 1999: Jan and Feb belong to the previous year
   assign jan_feb    = (tm.month < 8'd3);
   assign yr_adj     = tm.year[6:0] + 7'd1 - 7'(jan_feb);
   assign yr_quarter = (8'(yr_adj) + 8'd3) >> 2;
   assign week_sum   = dtv_pkg::WEEK_BASE + 8'(yr_adj) + yr_quarter
                     + 8'(dtv_pkg::month_shift(tm.month[3:0])) + 8'(tm.day[4:0]);

   always_comb begin
      chk.weekday = dtv_pkg::mod7(week_sum) + 3'd1;
      if (!date_ok) begin
         chk.status = dtv_pkg::STATUS_BAD_DATE;
      end else if (!time_ok) begin
         chk.status = dtv_pkg::STATUS_BAD_TIME;
      end else begin
         chk.status = dtv_pkg::STATUS_OK;
      end
   end

endmodule

[sv/dtv_encode.sv]
// Packs validated fields into BCD, zeroing all BCD fields on an error status.
// Depends on dtv_pkg.
module dtv_encode (
   input  dtv_pkg::dtv_time_type   tm,
   input  dtv_pkg::dtv_check_type  chk,
   output dtv_pkg::dtv_result_type res
);

   logic [7:0] sec_b;
   logic [7:0] min_b;
   logic [7:0] hour_b;
   logic [7:0] day_b;
   logic [7:0] mon_b;
   logic [7:0] year_b;

   assign sec_b  = dtv_pkg::to_bcd(tm.second[6:0]);
   assign min_b  = dtv_pkg::to_bcd(tm.minute[6:0]);
   assign hour_b = dtv_pkg::to_bcd(tm.hour[6:0]);
   assign day_b  = dtv_pkg::to_bcd(tm.day[6:0]);
   assign mon_b  = dtv_pkg::to_bcd(tm.month[6:0]);
   assign year_b = dtv_pkg::to_bcd(tm.year[6:0]);

   always_comb begin
      res = '0;
      res.status = chk.status;
      if (chk.status == dtv_pkg::STATUS_OK) begin
         res.second_bcd  = sec_b[6:0];
         res.minute_bcd  = min_b[6:0];
         res.hour_bcd    = hour_b[5:0];
         res.weekday_bcd = chk.weekday;
         res.day_bcd     = day_b[5:0];
         res.month_bcd   = mon_b[4:0];
         res.year_bcd    = year_b;
      end
   end

endmodule

[sv/date_time_validate_bcd_encoder_core.sv]
// Top level: input register, check and encode logic, result register.
// Depends on dtv_pkg, dtv_check and dtv_encode.
//
//   channel | ports                        | direction | moves
//   req     | req_valid/req_ready + 6 x 8b | in        | one raw date and time
//   rsp     | rsp_valid/rsp_ready + 8 flds | out       | status and BCD bytes
//
// A request transaction passes the input register, the check and encode
// logic and the result register; one transaction per cycle is sustained
// while rsp_ready holds, set by the single logic pass between the registers.
// Reset clears both stage valid flags; the data registers are not reset.
// A stalled result holds in place and the input stage fills behind it, after
// which req_ready drops until rsp_ready returns.
module date_time_validate_bcd_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_year_in,
   input  logic [7:0] req_month_in,
   input  logic [7:0] req_day_in,
   input  logic [7:0] req_hour_in,
   input  logic [7:0] req_minute_in,
   input  logic [7:0] req_second_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_second_bcd,
   output logic [6:0] rsp_minute_bcd,
   output logic [5:0] rsp_hour_bcd,
   output logic [2:0] rsp_weekday_bcd,
   output logic [5:0] rsp_day_bcd,
   output logic [4:0] rsp_month_bcd,
   output logic [7:0] rsp_year_bcd
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   dtv_pkg::dtv_time_type   in_data_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   dtv_pkg::dtv_result_type out_data_ff;
   dtv_pkg::dtv_check_type  chk;
   dtv_pkg::dtv_result_type res;
   logic                    out_adv;
   logic                    req_take;

   assign out_adv   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_adv;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (out_adv ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= '{year: req_year_in, month: req_month_in, day: req_day_in,
                         hour: req_hour_in, minute: req_minute_in,
                         second: req_second_in};
      end
      if (out_adv && in_valid_ff) begin
         out_data_ff <= res;
      end
   end

   dtv_check u_check (
      .tm  (in_data_ff),
      .chk (chk)
   );

   dtv_encode u_encode (
      .tm  (in_data_ff),
      .chk (chk),
      .res (res)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_data_ff.status;
   assign rsp_second_bcd  = out_data_ff.second_bcd;
   assign rsp_minute_bcd  = out_data_ff.minute_bcd;
   assign rsp_hour_bcd    = out_data_ff.hour_bcd;
   assign rsp_weekday_bcd = out_data_ff.weekday_bcd;
   assign rsp_day_bcd     = out_data_ff.day_bcd;
   assign rsp_month_bcd   = out_data_ff.month_bcd;
   assign rsp_year_bcd    = out_data_ff.year_bcd;

   // Error results carry all-zero BCD bytes
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dtv_pkg::STATUS_OK) |->
      (rsp_second_bcd == 7'd0 && rsp_minute_bcd == 7'd0 && rsp_hour_bcd == 6'd0
       && rsp_weekday_bcd == 3'd0 && rsp_day_bcd == 6'd0 && rsp_month_bcd == 5'd0
       && rsp_year_bcd == 8'd0))
      else $error("error result with nonzero BCD fields");

   // Good results always name a weekday
   a_ok_weekday: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dtv_pkg::STATUS_OK) |-> (rsp_weekday_bcd != 3'd0))
      else $error("valid result without weekday");

   // A blocked input stage keeps its transaction
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_adv) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input stage lost a held transaction");

   // No request is taken over an occupied, blocked input stage
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_adv) |-> !req_ready)
      else $error("input stage overrun");

endmodule
